// ===== rtl/adv_data_name_extractor_assert.svh =====
`ifndef ADV_DATA_NAME_EXTRACTOR_ASSERT_SVH
`define ADV_DATA_NAME_EXTRACTOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ADNE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adne assertion failed");

// next-cycle implication, checked out of reset
`define ADNE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adne assertion failed");

`endif

// ===== rtl/adne_pkg.sv =====
package adne_pkg;

    localparam logic [7:0] NAME_TYPE_SHORT    = 8'h08;
    localparam logic [7:0] NAME_TYPE_COMPLETE = 8'h09;
    localparam logic [7:0] CAPACITY_RESET     = 8'd29;

    localparam logic REG_NAME_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        PH_LEN  = 3'd0,
        PH_TYPE = 3'd1,
        PH_SKIP = 3'd2,
        PH_NAME = 3'd3,
        PH_DONE = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_BYTE    = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_NONAME  = 3'd2,
        ST_OVERRUN = 3'd3,
        ST_TOOLONG = 3'd4
    } t_status;

endpackage

// ===== rtl/adv_data_name_extractor.sv =====
// Local name extractor for advertising / extended inquiry data records.
// Input channel: one record byte per word (i_data_byte, i_record_start on the
// first byte of a record, i_record_length on every byte), taken when
// i_in_valid is high and o_in_stall is low.
// Output channel: zero or one result word per input word (o_name_byte,
// o_name_last, o_status), taken when o_out_valid is high and i_out_stall low.
// Status 0 carries a name byte, the last one flagged by o_name_last; status
// 1 to 4 report empty name, no name field, field overrun and name too long.
// After the first final result, bytes are dropped until the next record start.
// A byte taken into the input register is parsed combinationally; its result is
// loaded into the result register when the byte advances. Throughput: one byte per
// cycle unless the receiver stalls, set by the parse between the two registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more byte; o_in_stall rises only once both are full.
// Reset (synchronous, active low) empties both registers, restarts the parse
// and sets name_capacity to 29. name_capacity is written over APB at address 0.
module adv_data_name_extractor
    import adne_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_record_start,
    input  logic [7:0]  i_record_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_name_byte,
    output logic        o_name_last,
    output logic [2:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "adv_data_name_extractor_assert.svh"

    logic       r_in_valid;
    logic       n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    logic [7:0] r_in_len;

    logic       r_out_valid;
    logic       n_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    t_status    r_out_status;

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_offset;
    logic [7:0] n_offset;
    logic [7:0] r_remain;
    logic [7:0] n_remain;
    logic [7:0] r_capacity;

    logic       in_accept;
    logic       advance;
    t_phase     eff_phase;
    logic [7:0] eff_offset;
    logic [7:0] eff_remain;
    logic [7:0] offset_inc;
    logic [7:0] remain_dec;
    logic       res_valid;
    logic [7:0] res_byte;
    logic       res_last;
    t_status    res_status;
    logic       cfg_write;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign cfg_write  = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NAME_CAPACITY) ? {24'd0, r_capacity} : 32'd0;

    assign o_out_valid = r_out_valid;
    assign o_name_byte = r_out_byte;
    assign o_name_last = r_out_last;
    assign o_status    = r_out_status;

    always_comb begin
        eff_phase  = r_in_start ? PH_LEN : r_phase;
        eff_offset = r_in_start ? 8'd0 : r_offset;
        eff_remain = r_in_start ? 8'd0 : r_remain;
        offset_inc = (eff_offset == 8'hFF) ? 8'hFF : eff_offset + 8'd1;
        remain_dec = (eff_remain != 8'd0) ? eff_remain - 8'd1 : 8'd0;

        n_phase    = eff_phase;
        n_offset   = eff_offset;
        n_remain   = eff_remain;
        res_valid  = 1'b0;
        res_byte   = 8'd0;
        res_last   = 1'b0;
        res_status = ST_BYTE;

        case (eff_phase)
            PH_LEN: begin
                if (eff_offset >= r_in_len || r_in_byte == 8'd0) begin
                    n_phase    = PH_DONE;
                    res_valid  = 1'b1;
                    res_status = ST_NONAME;
                end else if ({2'b00, eff_offset} + 10'd1 + {2'b00, r_in_byte}
                             > {2'b00, r_in_len}) begin
                    n_phase    = PH_DONE;
                    res_valid  = 1'b1;
                    res_status = ST_OVERRUN;
                end else begin
                    n_offset = offset_inc;
                    n_remain = r_in_byte - 8'd1;
                    n_phase  = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_offset = offset_inc;
                if (r_in_byte == NAME_TYPE_SHORT || r_in_byte == NAME_TYPE_COMPLETE) begin
                    n_phase = PH_DONE;
                    if (eff_remain == 8'd0) begin
                        res_valid  = 1'b1;
                        res_status = ST_EMPTY;
                    end else if (eff_remain > r_capacity) begin
                        res_valid  = 1'b1;
                        res_status = ST_TOOLONG;
                    end else begin
                        n_phase = PH_NAME;
                    end
                end else if (eff_remain == 8'd0) begin
                    if (offset_inc >= r_in_len) begin
                        n_phase    = PH_DONE;
                        res_valid  = 1'b1;
                        res_status = ST_NONAME;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_offset = offset_inc;
                n_remain = remain_dec;
                if (remain_dec == 8'd0) begin
                    if (offset_inc >= r_in_len) begin
                        n_phase    = PH_DONE;
                        res_valid  = 1'b1;
                        res_status = ST_NONAME;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
            end
            PH_NAME: begin
                n_offset  = offset_inc;
                n_remain  = remain_dec;
                res_valid = 1'b1;
                res_byte  = r_in_byte;
                if (remain_dec == 8'd0) begin
                    n_phase  = PH_DONE;
                    res_last = 1'b1;
                end
            end
            default: begin
                n_phase = eff_phase;
            end
        endcase
    end

    always_comb begin
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end

        if (advance) begin
            n_out_valid = res_valid;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_LEN;
            r_offset    <= 8'd0;
            r_remain    <= 8'd0;
            r_capacity  <= CAPACITY_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_phase  <= n_phase;
                r_offset <= n_offset;
                r_remain <= n_remain;
            end
            if (cfg_write && paddr[2] == REG_NAME_CAPACITY) begin
                r_capacity <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_record_start;
            r_in_len   <= i_record_length;
        end
        if (advance && res_valid) begin
            r_out_byte   <= res_byte;
            r_out_last   <= res_last;
            r_out_status <= res_status;
        end
    end

    `ADNE_ASSERT_NEXT(a_last_ends_parse, i_clk, i_rst_n,
        advance && res_valid && res_last, r_phase == PH_DONE)
    `ADNE_ASSERT_NOW(a_name_has_bytes, i_clk, i_rst_n,
        r_phase == PH_NAME, r_remain != 8'd0)
    `ADNE_ASSERT_NOW(a_skip_has_bytes, i_clk, i_rst_n,
        r_phase == PH_SKIP, r_remain != 8'd0)
    `ADNE_ASSERT_NOW(a_stall_needs_word, i_clk, i_rst_n,
        o_in_stall, r_in_valid && r_out_valid && i_out_stall)
    `ADNE_ASSERT_NOW(a_last_only_on_byte, i_clk, i_rst_n,
        r_out_valid && r_out_last, r_out_status == ST_BYTE)

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import adne_pkg::*;

    typedef logic [7:0] t_byte_seq[$];

    typedef struct packed {
        logic [7:0] name_byte;
        logic       name_last;
        t_status    status;
    } t_name_result;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 4;
    localparam int CHUNK_WORDS = 100;
    localparam logic [2:0] CAP_ADDR = {REG_NAME_CAPACITY, 2'b00};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_record_start = 1'b0;
    logic [7:0]  i_record_length = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_name_byte;
    logic        o_name_last;
    logic [2:0]  o_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // parser copy
    t_phase       parse_phase = PH_LEN;
    logic [7:0]   rec_offset = '0;
    logic [7:0]   field_left = '0;
    logic [7:0]   name_cap = CAPACITY_RESET;
    t_name_result expected_names[$];

    int mismatches = 0;
    int sent_words = 0;
    int quiet_cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;

    adv_data_name_extractor u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_record_start  (i_record_start),
        .i_record_length (i_record_length),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_name_byte     (o_name_byte),
        .o_name_last     (o_name_last),
        .o_status        (o_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void report_mismatch(string what);
        mismatches++;
        if (mismatches <= 10) $display("%s", what);
    endfunction

    function automatic void push_result(logic [7:0] b, logic last, t_status st);
        t_name_result r;
        r.name_byte = b;
        r.name_last = last;
        r.status = st;
        expected_names.push_back(r);
    endfunction

    function automatic void step_offset();
        if (rec_offset != 8'hFF) rec_offset++;
    endfunction

    function automatic void end_of_field(logic [7:0] rl);
        if (rec_offset >= rl) begin
            parse_phase = PH_DONE;
            push_result(8'h00, 1'b0, ST_NONAME);
        end else begin
            parse_phase = PH_LEN;
        end
    endfunction

    function automatic void predict_name_word(logic [7:0] b, logic st, logic [7:0] rl);
        sent_words++;
        if (st) begin
            parse_phase = PH_LEN;
            rec_offset = '0;
            field_left = '0;
        end
        case (parse_phase)
            PH_LEN: begin
                if (rec_offset >= rl || b == 8'h00) begin
                    parse_phase = PH_DONE;
                    push_result(8'h00, 1'b0, ST_NONAME);
                end else if (9'(rec_offset) + 9'd1 + 9'(b) > 9'(rl)) begin
                    parse_phase = PH_DONE;
                    push_result(8'h00, 1'b0, ST_OVERRUN);
                end else begin
                    step_offset();
                    field_left = b - 8'd1;
                    parse_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                step_offset();
                if (b == NAME_TYPE_SHORT || b == NAME_TYPE_COMPLETE) begin
                    parse_phase = PH_DONE;
                    if (field_left == 8'd0) push_result(8'h00, 1'b0, ST_EMPTY);
                    else if (field_left > name_cap) push_result(8'h00, 1'b0, ST_TOOLONG);
                    else parse_phase = PH_NAME;
                end else if (field_left == 8'd0) begin
                    end_of_field(rl);
                end else begin
                    parse_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                step_offset();
                if (field_left > 8'd0) field_left--;
                if (field_left == 8'd0) end_of_field(rl);
            end
            PH_NAME: begin
                step_offset();
                if (field_left > 8'd0) field_left--;
                if (field_left == 8'd0) begin
                    parse_phase = PH_DONE;
                    push_result(b, 1'b1, ST_BYTE);
                end else begin
                    push_result(b, 1'b0, ST_BYTE);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : result_monitor
        t_name_result want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                predict_name_word(i_data_byte, i_record_start, i_record_length);
            if (o_out_valid && !i_out_stall) begin
                if (expected_names.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: byte %02h last %b status %0d",
                                              o_name_byte, o_name_last, o_status));
                end else begin
                    want = expected_names.pop_front();
                    if (o_name_byte !== want.name_byte || o_name_last !== want.name_last ||
                        o_status !== want.status)
                        report_mismatch($sformatf(
                            "result mismatch: expected byte %02h last %b status %0d, got byte %02h last %b status %0d",
                            want.name_byte, want.name_last, want.status,
                            o_name_byte, o_name_last, o_status));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL adv_data_name_extractor");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < recv_gap);

    task automatic send_word(logic [7:0] b, logic st, logic [7:0] rl);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_record_start <= st;
        i_record_length <= rl;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_record(t_byte_seq seq, logic [7:0] rl, bit with_start);
        foreach (seq[i]) send_word(seq[i], with_start && i == 0, rl);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_names.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [7:0] val);
        wait_idle();
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAP_ADDR;
        pwdata <= 32'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        name_cap = val;
        // read back
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(val))
            report_mismatch($sformatf("capacity readback: expected %08h, got %08h",
                                      32'(val), prdata));
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_start_free_parse();
        t_byte_seq seq;
        seq = {8'd3, NAME_TYPE_SHORT, 8'h41, 8'h42};
        send_record(seq, 8'd4, 1'b0);
    endtask

    task automatic test_status_cases();
        t_byte_seq seq;
        seq = {8'd0};
        send_record(seq, 8'd5, 1'b1);
        seq = {8'd1};
        send_record(seq, 8'd0, 1'b1);
        seq = {8'd3};
        send_record(seq, 8'd3, 1'b1);
        seq = {8'd2, 8'hFF, 8'h00};
        send_record(seq, 8'd3, 1'b1);
        seq = {8'd1, NAME_TYPE_COMPLETE};
        send_record(seq, 8'd2, 1'b1);
        seq = {8'd31, NAME_TYPE_SHORT};
        send_record(seq, 8'd255, 1'b1);
        // restart in the middle of a skipped field
        seq = {8'd5, 8'h01, 8'hAA};
        send_record(seq, 8'd9, 1'b1);
        seq = {8'd2, NAME_TYPE_COMPLETE, 8'hFF};
        send_record(seq, 8'd3, 1'b1);
        // record length shrinks under a skipped field
        send_word(8'd2, 1'b1, 8'd6);
        send_word(8'h01, 1'b0, 8'd6);
        send_word(8'h55, 1'b0, 8'd3);
        send_word(NAME_TYPE_COMPLETE, 1'b0, 8'd255);
    endtask

    task automatic test_capacity_edges();
        t_byte_seq seq;
        write_capacity(8'd2);
        seq = {8'd3, NAME_TYPE_SHORT, 8'h68, 8'h69};
        send_record(seq, 8'd4, 1'b1);
        seq = {8'd4, NAME_TYPE_SHORT};
        send_record(seq, 8'd5, 1'b1);
        write_capacity(8'd0);
        seq = {8'd2, NAME_TYPE_COMPLETE};
        send_record(seq, 8'd3, 1'b1);
    endtask

    task automatic send_random_record();
        t_byte_seq seq;
        int kind, flen, body_len, room, rl, alt_idx, alt_rl, top;
        logic [7:0] tcode;
        kind = $urandom_range(99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 12))
                send_word(8'($urandom), $urandom_range(3) == 0, 8'($urandom));
            return;
        end
        repeat ($urandom_range(0, 3)) begin
            flen = $urandom_range(1, 5);
            seq.push_back(8'(flen));
            do tcode = 8'($urandom);
            while (tcode == NAME_TYPE_SHORT || tcode == NAME_TYPE_COMPLETE);
            seq.push_back(tcode);
            repeat (flen - 1) seq.push_back(8'($urandom));
        end
        if (kind < 80) begin
            room = 252 - seq.size();
            top = (name_cap < 14) ? int'(name_cap) + 2 : 16;
            if ($urandom_range(19) == 0) body_len = $urandom_range(0, 254);
            else body_len = $urandom_range(0, top);
            if (body_len > room) body_len = room;
            seq.push_back(8'(body_len + 1));
            seq.push_back($urandom_range(1) ? NAME_TYPE_COMPLETE : NAME_TYPE_SHORT);
            repeat (body_len) seq.push_back(8'($urandom));
        end
        if ($urandom_range(1) || seq.size() == 0) seq.push_back(8'h00);
        rl = seq.size();
        alt_idx = -1;
        alt_rl = $urandom_range(0, 255);
        case ($urandom_range(9))
            0: rl = (rl > 3) ? rl - $urandom_range(1, 3) : 0;
            1: rl = $urandom_range(0, 255);
            2: rl = (rl + 4 > 255) ? 255 : rl + $urandom_range(1, 4);
            3: alt_idx = $urandom_range(0, seq.size() - 1);
            default: ;
        endcase
        foreach (seq[i])
            send_word(seq[i], i == 0 && $urandom_range(19) != 0,
                      8'((alt_idx >= 0 && i >= alt_idx) ? alt_rl : rl));
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0, 8'(rl));
    endtask

    task automatic test_random_traffic(int sender_idle, int receiver_idle);
        int target;
        logic [7:0] cap;
        send_gap = sender_idle;
        recv_gap = receiver_idle;
        for (int c = 0; c < 5; c++) begin
            case (c)
                0: cap = 8'($urandom_range(1, 12));
                1: cap = 8'd255;
                2: cap = 8'd0;
                3: cap = 8'($urandom_range(0, 255));
                default: cap = 8'($urandom_range(3, 20));
            endcase
            write_capacity(cap);
            target = sent_words + CHUNK_WORDS;
            while (sent_words < target) send_random_record();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_start_free_parse();
        test_status_cases();
        test_capacity_edges();
        test_random_traffic(17, 52);
        test_random_traffic(52, 17);
        test_random_traffic(0, 0);
        wait_idle();
        if (mismatches == 0)
            $display("PASS adv_data_name_extractor");
        else
            $display("FAIL adv_data_name_extractor");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/adne_pkg.sv
rtl/adv_data_name_extractor.sv
test/tb_top.sv
